[hw/rtl/uvs_pkg.sv]
package uvs_pkg;

  localparam int MAX_COUNT  = 1024;
  localparam int CNT_W      = 11;
  localparam int ADDR_W     = 4;

  // long division of the clamped index by its count
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = 11;
  localparam int QW         = DIV_STEPS * DIV_STAGES + 1;

  // sine and cosine pipeline
  localparam int HORNER     = 5;
  localparam int SC_LAT     = 3 + 3 * HORNER + 2;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam logic [6:0] SIN_K [HORNER] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_K [HORNER] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

  localparam logic [31:0] SIN_RECIP [HORNER] = '{
    32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
    32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6)
  };
  localparam logic [31:0] COS_RECIP [HORNER] = '{
    32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
    32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)
  };

  typedef enum logic [1:0] {
    REG_SECTOR_COUNT = 2'd0,
    REG_RING_COUNT   = 2'd1,
    REG_DIAMETER     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] ring_index;
    logic [10:0] sector_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [20:0]        quad_base;
    logic               quad_valid;
  } out_t;

  // per-item values that ride alongside the trig pipeline
  typedef struct packed {
    logic [20:0] quad_base;
    logic        quad_valid;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } side_t;

  typedef struct packed {
    logic [1:0]  quad;
    logic        neg;
    logic [29:0] x;
    logic [29:0] x2;
  } sc_side_t;

endpackage

[hw/rtl/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator.
// Input channel (in_valid / in_stall / in_data): one beat names a grid point by
// ring and sector index; indices above the configured counts are clamped.
// Result channel (out_valid / out_stall / out_data): one beat per input beat, in
// order, carrying position, normal, tangent, texture coordinates and the base
// vertex index of the quad at that point.
// Configuration: APB-style registers sector_count (0x0), ring_count (0x4) and
// diameter (0x8); write them only while no beat is in flight.
// Throughput: one beat per cycle while in_stall is low. The accepting edge
// loads the input stage; eleven divider stages, the angle stage, twenty
// sine/cosine stages, four normal/position stages and the output register
// follow, and out_valid rises when the beat reaches the output register.
// When the receiver stalls, the result held in the output register waits and one
// more beat drops into the skid register; in_stall is then raised and the whole
// pipeline holds until the skid register drains.
// Reset (rst_n low, synchronous) empties the pipeline and loads 32 sectors,
// 16 rings and a diameter of 1.0.
module uv_sphere_vertex_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  uvs_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output uvs_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uvs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CW = uvs_pkg::CNT_W;
  localparam int QW = uvs_pkg::QW;
  localparam int DS = uvs_pkg::DIV_STEPS;
  localparam int NS = uvs_pkg::DIV_STAGES;

  function automatic logic [CW-1:0] eff_count(logic [CW-1:0] c);
    if (c == '0) return CW'(1);
    if (c > CW'(uvs_pkg::MAX_COUNT)) return CW'(uvs_pkg::MAX_COUNT);
    return c;
  endfunction

  // a few restoring division steps: new remainder and quotient bits
  function automatic logic [CW+DS-1:0] div_steps(logic [CW-1:0] rem, logic [CW-1:0] den);
    logic [CW:0]   acc;
    logic [DS-1:0] bits;
    acc  = {1'b0, rem};
    bits = '0;
    for (int k = 0; k < DS; k++) begin
      acc  = {acc[CW-1:0], 1'b0};
      bits = bits << 1;
      if (acc >= {1'b0, den}) begin
        acc     = acc - {1'b0, den};
        bits[0] = 1'b1;
      end
    end
    return {acc[CW-1:0], bits};
  endfunction

  function automatic logic [15:0] sat16(logic neg, logic [16:0] mag);
    logic [16:0] mm;
    if (!neg) return (mag > 17'd32767) ? 16'd32767 : mag[15:0];
    mm = (mag > 17'd32768) ? 17'd32768 : mag;
    return 16'(~mm + 17'd1);
  endfunction

  function automatic logic [15:0] q30_out(logic neg, logic [30:0] mag);
    logic [31:0] sum;
    sum = 32'(mag) + 32'h0000_4000;
    return sat16(neg, sum[31:15]);
  endfunction

  function automatic logic [30:0] mag31(logic signed [31:0] v);
    logic [31:0] u;
    u = v[31] ? 32'(-v) : 32'(v);
    return u[30:0];
  endfunction

  // ---------------------------------------------------------------- registers
  logic [CW-1:0] sector_count_r, ring_count_r;
  logic [15:0]   diameter_r;
  uvs_pkg::reg_idx_t widx;

  assign pready = 1'b1;
  assign widx   = uvs_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= CW'(32);
      ring_count_r   <= CW'(16);
      diameter_r     <= 16'd256;
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        uvs_pkg::REG_SECTOR_COUNT: sector_count_r <= pwdata[CW-1:0];
        uvs_pkg::REG_RING_COUNT:   ring_count_r   <= pwdata[CW-1:0];
        uvs_pkg::REG_DIAMETER:     diameter_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      uvs_pkg::REG_SECTOR_COUNT: prdata = 32'(sector_count_r);
      uvs_pkg::REG_RING_COUNT:   prdata = 32'(ring_count_r);
      uvs_pkg::REG_DIAMETER:     prdata = 32'(diameter_r);
      default:                   prdata = '0;
    endcase
  end

  logic [CW-1:0] cnt_s, cnt_r;
  assign cnt_s = eff_count(sector_count_r);
  assign cnt_r = eff_count(ring_count_r);

  // --------------------------------------------------------- pipeline control
  // The whole pipeline advances together; only a full skid register halts it.
  logic en, skid_v_r;
  assign en       = ~skid_v_r;
  assign in_stall = skid_v_r;

  // ------------------------------------------------------ input stage: clamp
  logic [CW-1:0] r_c, s_c;
  logic          i_v_r, i_qv_r, i_qs_r, i_qr_r;
  logic [CW-1:0] i_r_r, i_s_r, i_rems_r, i_remr_r;

  assign r_c = (in_data.ring_index > cnt_r) ? cnt_r : in_data.ring_index;
  assign s_c = (in_data.sector_index > cnt_s) ? cnt_s : in_data.sector_index;

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (en) i_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_r_r    <= r_c;
      i_s_r    <= s_c;
      i_qv_r   <= (r_c < cnt_r) && (s_c < cnt_s);
      // integer bit of index/count: set only at the far edge of the grid
      i_qs_r   <= (s_c == cnt_s);
      i_qr_r   <= (r_c == cnt_r);
      i_rems_r <= (s_c == cnt_s) ? '0 : s_c;
      i_remr_r <= (r_c == cnt_r) ? '0 : r_c;
    end
  end

  // ------------------------------------------- divider: index * 2^33 / count
  logic          dv_i   [NS];
  logic [CW-1:0] drs_i  [NS];
  logic [CW-1:0] drr_i  [NS];
  logic [QW-1:0] dqs_i  [NS];
  logic [QW-1:0] dqr_i  [NS];
  logic [20:0]   dqb_i  [NS];
  logic          dqv_i  [NS];

  logic          d_v_r    [NS];
  logic [CW-1:0] d_rems_r [NS];
  logic [CW-1:0] d_remr_r [NS];
  logic [QW-1:0] d_qs_r   [NS];
  logic [QW-1:0] d_qr_r   [NS];
  logic [20:0]   d_qb_r   [NS];
  logic          d_qv_r   [NS];

  for (genvar j = 0; j < NS; j++) begin : g_div
    logic [CW+DS-1:0] ns, nr;

    if (j == 0) begin : g_first
      logic [CW+12:0] qb_full;
      assign qb_full  = (CW+13)'(i_r_r) * (CW+13)'(cnt_s + CW'(1)) + (CW+13)'(i_s_r);
      assign dv_i[j]  = i_v_r;
      assign drs_i[j] = i_rems_r;
      assign drr_i[j] = i_remr_r;
      assign dqs_i[j] = QW'(i_qs_r);
      assign dqr_i[j] = QW'(i_qr_r);
      assign dqb_i[j] = qb_full[20:0];
      assign dqv_i[j] = i_qv_r;
    end else begin : g_next
      assign dv_i[j]  = d_v_r[j-1];
      assign drs_i[j] = d_rems_r[j-1];
      assign drr_i[j] = d_remr_r[j-1];
      assign dqs_i[j] = d_qs_r[j-1];
      assign dqr_i[j] = d_qr_r[j-1];
      assign dqb_i[j] = d_qb_r[j-1];
      assign dqv_i[j] = d_qv_r[j-1];
    end

    assign ns = div_steps(drs_i[j], cnt_s);
    assign nr = div_steps(drr_i[j], cnt_r);

    always_ff @(posedge clk) begin
      if (!rst_n) d_v_r[j] <= 1'b0;
      else if (en) d_v_r[j] <= dv_i[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rems_r[j] <= ns[CW+DS-1:DS];
        d_remr_r[j] <= nr[CW+DS-1:DS];
        d_qs_r[j]   <= {dqs_i[j][QW-DS-1:0], ns[DS-1:0]};
        d_qr_r[j]   <= {dqr_i[j][QW-DS-1:0], nr[DS-1:0]};
        d_qb_r[j]   <= dqb_i[j];
        d_qv_r[j]   <= dqv_i[j];
      end
    end
  end

  // ---------------------------------------- angle stage: round the quotients
  logic [QW-1:0]  qs, qr;
  logic [QW:0]    th_sum;
  logic [QW-1:0]  ph_sum;
  logic [QW-17:0] tu_sum, tv_sum;
  logic           t_v_r;
  logic [31:0]    t_th_r, t_ph_r;
  uvs_pkg::side_t t_side_r;

  assign qs     = d_qs_r[NS-1];
  assign qr     = d_qr_r[NS-1];
  assign th_sum = (QW+1)'(qs) + (QW+1)'(1);
  assign ph_sum = QW'(qr[QW-1:1]) + QW'(1);
  assign tu_sum = (QW-16)'(qs[QW-1:17]) + (QW-16)'(1);
  assign tv_sum = (QW-16)'(qr[QW-1:17]) + (QW-16)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) t_v_r <= 1'b0;
    else if (en) t_v_r <= d_v_r[NS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_th_r              <= th_sum[32:1];
      t_ph_r              <= ph_sum[32:1];
      t_side_r.quad_base  <= d_qb_r[NS-1];
      t_side_r.quad_valid <= d_qv_r[NS-1];
      t_side_r.tex_u      <= tu_sum[16:1];
      t_side_r.tex_v      <= tv_sum[16:1];
    end
  end

  // ------------------------------------------------------- sine and cosine
  logic               sc_th_v, sc_ph_v;
  logic signed [31:0] st, ct, sp, cp;

  uvs_sincos u_sc_theta (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (t_v_r),
    .ang_i (t_th_r),
    .vld_o (sc_th_v),
    .sin_o (st),
    .cos_o (ct)
  );

  uvs_sincos u_sc_phi (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (t_v_r),
    .ang_i (t_ph_r),
    .vld_o (sc_ph_v),
    .sin_o (sp),
    .cos_o (cp)
  );

  // hold the side values for as long as the trig pipeline takes
  uvs_pkg::side_t sd_r [uvs_pkg::SC_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= t_side_r;
      for (int k = 1; k < uvs_pkg::SC_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // ------------------------------------------------------- normal products
  logic           n1_v_r, n1_negx_r, n1_negy_r, n1_negz_r;
  logic [61:0]    n1_px_r, n1_py_r;
  logic [30:0]    n1_mz_r;
  logic [15:0]    n1_tx_r, n1_ty_r;
  uvs_pkg::side_t n1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n1_v_r <= 1'b0;
    else if (en) n1_v_r <= sc_th_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_px_r   <= 62'(mag31(ct)) * 62'(mag31(sp));
      n1_py_r   <= 62'(mag31(st)) * 62'(mag31(sp));
      n1_negx_r <= ct[31] ^ sp[31];
      n1_negy_r <= st[31] ^ sp[31];
      n1_negz_r <= cp[31];
      n1_mz_r   <= mag31(cp);
      // tangent x is minus sin theta: negative where the sine is positive
      n1_tx_r   <= q30_out(~st[31] && (st != '0), mag31(st));
      n1_ty_r   <= q30_out(ct[31], mag31(ct));
      n1_side_r <= sd_r[uvs_pkg::SC_LAT-1];
    end
  end

  // --------------------------------------------------------- normal rounding
  logic [61:0]    px_sum, py_sum;
  logic           n2_v_r, n2_negx_r, n2_negy_r, n2_negz_r;
  logic [30:0]    n2_mx_r, n2_my_r, n2_mz_r;
  logic [15:0]    n2_tx_r, n2_ty_r;
  uvs_pkg::side_t n2_side_r;

  assign px_sum = n1_px_r + 62'h2000_0000;
  assign py_sum = n1_py_r + 62'h2000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) n2_v_r <= 1'b0;
    else if (en) n2_v_r <= n1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_mx_r   <= px_sum[60:30];
      n2_my_r   <= py_sum[60:30];
      n2_mz_r   <= n1_mz_r;
      n2_negx_r <= n1_negx_r;
      n2_negy_r <= n1_negy_r;
      n2_negz_r <= n1_negz_r;
      n2_tx_r   <= n1_tx_r;
      n2_ty_r   <= n1_ty_r;
      n2_side_r <= n1_side_r;
    end
  end

  // ------------------------------------------- radius products, normals out
  logic           p1_v_r, p1_negx_r, p1_negy_r, p1_negz_r;
  logic [46:0]    p1_px_r, p1_py_r, p1_pz_r;
  logic [15:0]    p1_nx_r, p1_ny_r, p1_nz_r, p1_tx_r, p1_ty_r;
  uvs_pkg::side_t p1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else if (en) p1_v_r <= n2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_px_r   <= 47'(n2_mx_r) * 47'(diameter_r);
      p1_py_r   <= 47'(n2_my_r) * 47'(diameter_r);
      p1_pz_r   <= 47'(n2_mz_r) * 47'(diameter_r);
      p1_negx_r <= n2_negx_r;
      p1_negy_r <= n2_negy_r;
      p1_negz_r <= n2_negz_r;
      p1_nx_r   <= q30_out(n2_negx_r, n2_mx_r);
      p1_ny_r   <= q30_out(n2_negy_r, n2_my_r);
      p1_nz_r   <= q30_out(n2_negz_r, n2_mz_r);
      p1_tx_r   <= n2_tx_r;
      p1_ty_r   <= n2_ty_r;
      p1_side_r <= n2_side_r;
    end
  end

  // -------------------------------------------------- positions, final beat
  logic [47:0]   pxs, pys, pzs;
  logic          p2_v_r;
  uvs_pkg::out_t p2_r;

  assign pxs = 48'(p1_px_r) + 48'h4000_0000;
  assign pys = 48'(p1_py_r) + 48'h4000_0000;
  assign pzs = 48'(p1_pz_r) + 48'h4000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else if (en) p2_v_r <= p1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r.pos_x      <= sat16(p1_negx_r, pxs[47:31]);
      p2_r.pos_y      <= sat16(p1_negy_r, pys[47:31]);
      p2_r.pos_z      <= sat16(p1_negz_r, pzs[47:31]);
      p2_r.norm_x     <= p1_nx_r;
      p2_r.norm_y     <= p1_ny_r;
      p2_r.norm_z     <= p1_nz_r;
      p2_r.tan_x      <= p1_tx_r;
      p2_r.tan_y      <= p1_ty_r;
      p2_r.tex_u      <= p1_side_r.tex_u;
      p2_r.tex_v      <= p1_side_r.tex_v;
      p2_r.quad_base  <= p1_side_r.quad_base;
      p2_r.quad_valid <= p1_side_r.quad_valid;
    end
  end

  // ------------------------------------------- output register and skid beat
  logic          out_valid_r, take;
  uvs_pkg::out_t out_r, skid_r;

  assign take      = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || take) begin
      // output free: refill from the skid beat first, else from the pipeline
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= p2_v_r;
      end
    end else if (p2_v_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_r <= skid_v_r ? skid_r : p2_r;
    end else if (p2_v_r && en) begin
      skid_r <= p2_r;
    end
  end

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid beat held with an empty output register");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  a_trig_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    sc_th_v == sc_ph_v)
    else $error("theta and phi trig pipelines out of step");

  a_quad_tex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.quad_valid) |->
      (out_r.tex_u != 16'h8000) && (out_r.tex_v != 16'h8000))
    else $error("texture coordinate of one on an existing quad");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid_r && !skid_v_r))
    else $error("beat present straight after reset");

endmodule

[hw/rtl/uvs_sincos.sv]
module uvs_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [31:0]        ang_i,
  output logic               vld_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  // floor(y/k) from y*floor(2^32/k), corrected by one compare
  function automatic logic [29:0] div_fix(logic [29:0] y, logic [61:0] prod, logic [6:0] k);
    logic [29:0] qe;
    logic [36:0] rr;
    qe = prod[61:32];
    rr = 37'(y) - 37'(qe) * 37'(k);
    return (rr >= 37'(k)) ? 30'(qe + 30'd1) : qe;
  endfunction

  logic [31:0] a;
  logic [29:0] m;
  logic [62:0] xprod;
  logic [59:0] x2prod;

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic [1:0]  s1_q_r, s2_q_r;
  logic        s1_neg_r, s2_neg_r;
  logic [29:0] s1_m_r, s2_x_r;
  uvs_pkg::sc_side_t s3_side_r;

  // fold to a residue within an eighth of a turn
  assign a = ang_i + 32'h2000_0000;
  assign m = a[29] ? {1'b0, a[28:0]} : 30'(30'h2000_0000 - {1'b0, a[28:0]});
  assign xprod  = 63'(s1_m_r) * 63'(uvs_pkg::PI_Q30) + 63'h4000_0000;
  assign x2prod = 60'(s2_x_r) * 60'(s2_x_r) + 60'h2000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= vld_i;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q_r   <= a[31:30];
      s1_neg_r <= ~a[29];
      s1_m_r   <= m;
      s2_q_r   <= s1_q_r;
      s2_neg_r <= s1_neg_r;
      s2_x_r   <= xprod[60:31];
      s3_side_r.quad <= s2_q_r;
      s3_side_r.neg  <= s2_neg_r;
      s3_side_r.x    <= s2_x_r;
      s3_side_r.x2   <= x2prod[59:30];
    end
  end

  // Horner steps: multiply, reciprocal multiply, correct and subtract
  logic              hi_v    [uvs_pkg::HORNER];
  logic [30:0]       hi_ts   [uvs_pkg::HORNER];
  logic [30:0]       hi_tc   [uvs_pkg::HORNER];
  uvs_pkg::sc_side_t hi_side [uvs_pkg::HORNER];

  logic              ha_v_r    [uvs_pkg::HORNER];
  logic [60:0]       ha_ps_r   [uvs_pkg::HORNER];
  logic [60:0]       ha_pc_r   [uvs_pkg::HORNER];
  uvs_pkg::sc_side_t ha_side_r [uvs_pkg::HORNER];
  logic              hb_v_r    [uvs_pkg::HORNER];
  logic [29:0]       hb_ys_r   [uvs_pkg::HORNER];
  logic [29:0]       hb_yc_r   [uvs_pkg::HORNER];
  logic [61:0]       hb_ms_r   [uvs_pkg::HORNER];
  logic [61:0]       hb_mc_r   [uvs_pkg::HORNER];
  uvs_pkg::sc_side_t hb_side_r [uvs_pkg::HORNER];
  logic              hc_v_r    [uvs_pkg::HORNER];
  logic [30:0]       hc_ts_r   [uvs_pkg::HORNER];
  logic [30:0]       hc_tc_r   [uvs_pkg::HORNER];
  uvs_pkg::sc_side_t hc_side_r [uvs_pkg::HORNER];

  for (genvar j = 0; j < uvs_pkg::HORNER; j++) begin : g_horner
    logic [60:0] ys_full, yc_full;

    if (j == 0) begin : g_first
      assign hi_v[j]    = s3_v_r;
      assign hi_ts[j]   = 31'h4000_0000;
      assign hi_tc[j]   = 31'h4000_0000;
      assign hi_side[j] = s3_side_r;
    end else begin : g_next
      assign hi_v[j]    = hc_v_r[j-1];
      assign hi_ts[j]   = hc_ts_r[j-1];
      assign hi_tc[j]   = hc_tc_r[j-1];
      assign hi_side[j] = hc_side_r[j-1];
    end

    assign ys_full = ha_ps_r[j] + 61'h2000_0000;
    assign yc_full = ha_pc_r[j] + 61'h2000_0000;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ha_v_r[j] <= 1'b0;
        hb_v_r[j] <= 1'b0;
        hc_v_r[j] <= 1'b0;
      end else if (en) begin
        ha_v_r[j] <= hi_v[j];
        hb_v_r[j] <= ha_v_r[j];
        hc_v_r[j] <= hb_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ha_ps_r[j]   <= 61'(hi_side[j].x2) * 61'(hi_ts[j]);
        ha_pc_r[j]   <= 61'(hi_side[j].x2) * 61'(hi_tc[j]);
        ha_side_r[j] <= hi_side[j];
        hb_ys_r[j]   <= ys_full[59:30];
        hb_yc_r[j]   <= yc_full[59:30];
        hb_ms_r[j]   <= 62'(ys_full[59:30]) * 62'(uvs_pkg::SIN_RECIP[j]);
        hb_mc_r[j]   <= 62'(yc_full[59:30]) * 62'(uvs_pkg::COS_RECIP[j]);
        hb_side_r[j] <= ha_side_r[j];
        hc_ts_r[j]   <= 31'(31'h4000_0000
                        - 31'(div_fix(hb_ys_r[j], hb_ms_r[j], uvs_pkg::SIN_K[j])));
        hc_tc_r[j]   <= 31'(31'h4000_0000
                        - 31'(div_fix(hb_yc_r[j], hb_mc_r[j], uvs_pkg::COS_K[j])));
        hc_side_r[j] <= hb_side_r[j];
      end
    end
  end

  localparam int LAST = uvs_pkg::HORNER - 1;

  logic [60:0] sprod;
  logic        f1_v_r;
  logic [1:0]  f1_q_r;
  logic        f1_neg_r;
  logic [30:0] f1_sm_r, f1_c_r;
  logic signed [31:0] sr, cr;

  assign sprod = 61'(hc_side_r[LAST].x) * 61'(hc_ts_r[LAST]) + 61'h2000_0000;
  assign sr    = f1_neg_r ? -$signed({1'b0, f1_sm_r}) : $signed({1'b0, f1_sm_r});
  assign cr    = $signed({1'b0, f1_c_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en) begin
      f1_v_r <= hc_v_r[LAST];
      vld_o  <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_q_r   <= hc_side_r[LAST].quad;
      f1_neg_r <= hc_side_r[LAST].neg;
      f1_sm_r  <= sprod[60:30];
      f1_c_r   <= hc_tc_r[LAST];
      // map the residue back to its quadrant
      case (f1_q_r)
        2'd0: begin
          sin_o <= sr;
          cos_o <= cr;
        end
        2'd1: begin
          sin_o <= cr;
          cos_o <= -sr;
        end
        2'd2: begin
          sin_o <= -sr;
          cos_o <= -cr;
        end
        default: begin
          sin_o <= -cr;
          cos_o <= sr;
        end
      endcase
    end
  end

endmodule
